### sv/twexp_pkg.sv
// Types, fixed-point helpers and elaboration-time constant functions for the
// twist exponential pipeline. Depends on nothing; imported by twist_exponential_top.
`default_nettype none

package twexp_pkg;

  typedef struct packed {
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] lin_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] angle;
  } tw_in_t;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } tw_out_t;

  localparam logic signed [47:0] ONE_Q30 = 48'sd1073741824;

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Product rounded by n bits, ties towards plus infinity.
  function automatic logic signed [47:0] mulrnd(input logic signed [32:0] a,
                                                input logic signed [32:0] b,
                                                input int n);
    logic signed [65:0] p;
    p = a * b;
    p = p + (66'sd1 <<< (n - 1));
    return 48'(p >>> n);
  endfunction

  function automatic logic signed [47:0] rndsh(input logic signed [47:0] x, input int n);
    return (x + (48'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Long division, used only while elaborating constants.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/m) in Q62 from the alternating series.
  function automatic logic [63:0] atan_inv(input logic [63:0] m);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p = udiv(64'd1 << 62, m);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        term = udiv(p, 64'(2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        p = udiv(udiv(p, m), m);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] nn;
    logic [63:0] r;
    logic [63:0] bt;
    nn = n;
    r = '0;
    bt = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bt > nn) bt = bt >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bt != 64'd0) begin
        if (nn >= r + bt) begin
          nn = nn - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic signed [47:0] pi4_q40();
    logic [63:0] p;
    p = 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
    return 48'((p + (64'd1 << 21)) >> 22);
  endfunction

  function automatic logic signed [47:0] atan_q40(input int i);
    if (i == 0) begin
      return pi4_q40();
    end
    return 48'((atan_inv(64'd1 << i) + (64'd1 << 21)) >> 22);
  endfunction

  // Reciprocal of the CORDIC gain in Q40 for the given number of iterations.
  function automatic logic signed [47:0] kgain_q40(input int steps);
    logic [63:0] p;
    logic [63:0] root;
    logic [63:0] q1;
    logic [63:0] r;
    p = 64'd1 << 60;
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 62) p = p + (p >> (2 * i));
    end
    root = isqrt64(p);
    q1 = udiv(64'd1 << 62, root);
    r = (64'd1 << 62) - q1 * root;
    return 48'((q1 << 8) + udiv(r << 8, root));
  endfunction

endpackage

`default_nettype wire

### sv/twist_exponential_top.sv
// Twist exponential: fold and CORDIC sine/cosine pipeline followed by the
// Rodrigues rotation and translation multiplier stages. Uses twexp_pkg.
//
// An accepted word passes the fold register, the CORDIC iteration stages and stages A to E.
// Throughput: one word per cycle; each CORDIC iteration is a stage of its own
// and every product has a register behind it.
// A stalled output word holds the whole pipeline for that cycle.
// Reset clears the valid bits of every stage; data registers are not reset.
`default_nettype none

module twist_exponential_top import twexp_pkg::*; #(
  parameter int CORDIC_STEPS = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire tw_in_t  in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output tw_out_t      out_data_o
);

  localparam logic signed [47:0] PI4  = pi4_q40();
  localparam logic signed [47:0] HALF = PI4 <<< 1;
  localparam logic signed [47:0] PI   = PI4 <<< 2;
  localparam logic signed [47:0] KG   = kgain_q40(CORDIC_STEPS);

  logic adv;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- fold and CORDIC stages ----------------
  logic               cv_q [CORDIC_STEPS+1];
  logic signed [47:0] cx_q [CORDIC_STEPS+1];
  logic signed [47:0] cy_q [CORDIC_STEPS+1];
  logic signed [47:0] cz_q [CORDIC_STEPS+1];
  logic               cn_q [CORDIC_STEPS+1];
  logic               cw0_q [CORDIC_STEPS+1];
  tw_in_t             cp_q [CORDIC_STEPS+1];

  logic signed [47:0] a_in;
  logic signed [47:0] z0_d;
  logic               n0_d;

  always_comb begin
    a_in = 48'(in_data_i.angle) <<< 11;
    z0_d = a_in;
    n0_d = 1'b0;
    if (a_in > HALF) begin
      z0_d = a_in - PI;
      n0_d = 1'b1;
    end else if (a_in < -HALF) begin
      z0_d = a_in + PI;
      n0_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (adv) begin
      cv_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0]  <= KG;
      cy_q[0]  <= '0;
      cz_q[0]  <= z0_d;
      cn_q[0]  <= n0_d;
      cw0_q[0] <= (in_data_i.axis_x == 32'sd0) && (in_data_i.axis_y == 32'sd0) &&
                  (in_data_i.axis_z == 32'sd0);
      cp_q[0]  <= in_data_i;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    localparam logic signed [47:0] AT = atan_q40(g);
    logic signed [47:0] x_d;
    logic signed [47:0] y_d;
    logic signed [47:0] z_d;

    always_comb begin
      if (!cz_q[g][47]) begin
        x_d = cx_q[g] - (cy_q[g] >>> g);
        y_d = cy_q[g] + (cx_q[g] >>> g);
        z_d = cz_q[g] - AT;
      end else begin
        x_d = cx_q[g] + (cy_q[g] >>> g);
        y_d = cy_q[g] - (cx_q[g] >>> g);
        z_d = cz_q[g] + AT;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[g+1] <= 1'b0;
      end else if (adv) begin
        cv_q[g+1] <= cv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[g+1]  <= x_d;
        cy_q[g+1]  <= y_d;
        cz_q[g+1]  <= z_d;
        cn_q[g+1]  <= cn_q[g];
        cw0_q[g+1] <= cw0_q[g];
        cp_q[g+1]  <= cp_q[g];
      end
    end
  end

  // ---------------- stage A: sine, cosine and first products ----------------
  logic               a_valid_q;
  tw_in_t             a_p_q;
  logic               a_zero_q;
  logic signed [31:0] a_s_q, a_s_d;
  logic signed [32:0] a_cc_q, a_cc_d;
  logic signed [31:0] a_ww_q [6];
  logic signed [31:0] a_ww_d [6];
  logic signed [31:0] a_u_q [3];
  logic signed [31:0] a_u_d [3];
  logic signed [31:0] a_dot_q, a_dot_d;

  logic signed [47:0] xf;
  logic signed [47:0] yf;
  logic signed [31:0] c_a;
  logic signed [32:0] wa [3];
  logic signed [32:0] va [3];

  always_comb begin
    xf = cn_q[CORDIC_STEPS] ? -cx_q[CORDIC_STEPS] : cx_q[CORDIC_STEPS];
    yf = cn_q[CORDIC_STEPS] ? -cy_q[CORDIC_STEPS] : cy_q[CORDIC_STEPS];
    c_a    = sat32(rndsh(xf, 10));
    a_s_d  = sat32(rndsh(yf, 10));
    a_cc_d = 33'sd1073741824 - 33'(c_a);
    wa[0] = 33'(cp_q[CORDIC_STEPS].axis_x);
    wa[1] = 33'(cp_q[CORDIC_STEPS].axis_y);
    wa[2] = 33'(cp_q[CORDIC_STEPS].axis_z);
    va[0] = 33'(cp_q[CORDIC_STEPS].lin_x);
    va[1] = 33'(cp_q[CORDIC_STEPS].lin_y);
    va[2] = 33'(cp_q[CORDIC_STEPS].lin_z);
    a_ww_d[0] = sat32(mulrnd(wa[0], wa[0], 30));
    a_ww_d[1] = sat32(mulrnd(wa[1], wa[1], 30));
    a_ww_d[2] = sat32(mulrnd(wa[2], wa[2], 30));
    a_ww_d[3] = sat32(mulrnd(wa[0], wa[1], 30));
    a_ww_d[4] = sat32(mulrnd(wa[0], wa[2], 30));
    a_ww_d[5] = sat32(mulrnd(wa[1], wa[2], 30));
    a_u_d[0] = sat32(mulrnd(wa[1], va[2], 30) - mulrnd(wa[2], va[1], 30));
    a_u_d[1] = sat32(mulrnd(wa[2], va[0], 30) - mulrnd(wa[0], va[2], 30));
    a_u_d[2] = sat32(mulrnd(wa[0], va[1], 30) - mulrnd(wa[1], va[0], 30));
    a_dot_d  = sat32(mulrnd(wa[0], va[0], 30) + mulrnd(wa[1], va[1], 30) +
                     mulrnd(wa[2], va[2], 30));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_p_q    <= cp_q[CORDIC_STEPS];
      a_zero_q <= cw0_q[CORDIC_STEPS];
      a_s_q    <= a_s_d;
      a_cc_q   <= a_cc_d;
      a_ww_q   <= a_ww_d;
      a_u_q    <= a_u_d;
      a_dot_q  <= a_dot_d;
    end
  end

  // ---------------- stage B: products with 1-c and s ----------------
  logic               b_valid_q;
  tw_in_t             b_p_q;
  logic               b_zero_q;
  logic signed [32:0] b_cc_q;
  logic signed [31:0] b_u_q [3];
  logic signed [31:0] b_dg_q [3];
  logic signed [31:0] b_dg_d [3];
  logic signed [31:0] b_off_q [3];
  logic signed [31:0] b_off_d [3];
  logic signed [31:0] b_ws_q [3];
  logic signed [31:0] b_ws_d [3];
  logic signed [31:0] b_k_q, b_k_d;

  always_comb begin
    b_dg_d[0] = sat32(48'(a_ww_q[1]) + 48'(a_ww_q[2]));
    b_dg_d[1] = sat32(48'(a_ww_q[0]) + 48'(a_ww_q[2]));
    b_dg_d[2] = sat32(48'(a_ww_q[0]) + 48'(a_ww_q[1]));
    b_off_d[0] = sat32(mulrnd(33'(a_ww_q[3]), a_cc_q, 30));
    b_off_d[1] = sat32(mulrnd(33'(a_ww_q[4]), a_cc_q, 30));
    b_off_d[2] = sat32(mulrnd(33'(a_ww_q[5]), a_cc_q, 30));
    b_ws_d[0] = sat32(mulrnd(33'(a_p_q.axis_x), 33'(a_s_q), 30));
    b_ws_d[1] = sat32(mulrnd(33'(a_p_q.axis_y), 33'(a_s_q), 30));
    b_ws_d[2] = sat32(mulrnd(33'(a_p_q.axis_z), 33'(a_s_q), 30));
    b_k_d = sat32(mulrnd(33'(a_dot_q), 33'(a_p_q.angle), 29));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_p_q    <= a_p_q;
      b_zero_q <= a_zero_q;
      b_cc_q   <= a_cc_q;
      b_u_q    <= a_u_q;
      b_dg_q   <= b_dg_d;
      b_off_q  <= b_off_d;
      b_ws_q   <= b_ws_d;
      b_k_q    <= b_k_d;
    end
  end

  // ---------------- stage C: rotation matrix ----------------
  logic               c_valid_q;
  tw_in_t             c_p_q;
  logic               c_zero_q;
  logic signed [31:0] c_u_q [3];
  logic signed [31:0] c_k_q;
  logic signed [31:0] c_r_q [9];
  logic signed [31:0] c_r_d [9];

  always_comb begin
    c_r_d[0] = sat32(ONE_Q30 - 48'(sat32(mulrnd(33'(b_dg_q[0]), b_cc_q, 30))));
    c_r_d[4] = sat32(ONE_Q30 - 48'(sat32(mulrnd(33'(b_dg_q[1]), b_cc_q, 30))));
    c_r_d[8] = sat32(ONE_Q30 - 48'(sat32(mulrnd(33'(b_dg_q[2]), b_cc_q, 30))));
    c_r_d[1] = sat32(48'(b_off_q[0]) - 48'(b_ws_q[2]));
    c_r_d[3] = sat32(48'(b_off_q[0]) + 48'(b_ws_q[2]));
    c_r_d[2] = sat32(48'(b_off_q[1]) + 48'(b_ws_q[1]));
    c_r_d[6] = sat32(48'(b_off_q[1]) - 48'(b_ws_q[1]));
    c_r_d[5] = sat32(48'(b_off_q[2]) - 48'(b_ws_q[0]));
    c_r_d[7] = sat32(48'(b_off_q[2]) + 48'(b_ws_q[0]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_p_q    <= b_p_q;
      c_zero_q <= b_zero_q;
      c_u_q    <= b_u_q;
      c_k_q    <= b_k_q;
      c_r_q    <= c_r_d;
    end
  end

  // ---------------- stage D: translation products ----------------
  logic               d_valid_q;
  logic               d_zero_q;
  logic signed [31:0] d_r_q [9];
  logic signed [47:0] d_pr_q [9];
  logic signed [47:0] d_pr_d [9];
  logic signed [47:0] d_pk_q [3];
  logic signed [47:0] d_pk_d [3];
  logic signed [31:0] d_pz_q [3];
  logic signed [31:0] d_pz_d [3];

  logic signed [32:0] wc [3];
  logic signed [32:0] vc [3];
  logic signed [32:0] dij;

  always_comb begin
    wc[0] = 33'(c_p_q.axis_x);
    wc[1] = 33'(c_p_q.axis_y);
    wc[2] = 33'(c_p_q.axis_z);
    vc[0] = 33'(c_p_q.lin_x);
    vc[1] = 33'(c_p_q.lin_y);
    vc[2] = 33'(c_p_q.lin_z);
    dij = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dij = ((i == j) ? 33'sd1073741824 : 33'sd0) - 33'(c_r_q[3*i+j]);
        d_pr_d[3*i+j] = mulrnd(dij, 33'(c_u_q[j]), 30);
      end
      d_pk_d[i] = mulrnd(33'(c_k_q), wc[i], 30);
      d_pz_d[i] = sat32(mulrnd(33'(c_p_q.angle), vc[i], 29));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_zero_q <= c_zero_q;
      d_r_q    <= c_r_q;
      d_pr_q   <= d_pr_d;
      d_pk_q   <= d_pk_d;
      d_pz_q   <= d_pz_d;
    end
  end

  // ---------------- stage E: output register ----------------
  logic    e_valid_q;
  tw_out_t out_q, out_d;
  logic signed [31:0] t_d [3];
  logic signed [31:0] r_d [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_zero_q) begin
        t_d[i] = d_pz_q[i];
      end else begin
        t_d[i] = sat32(d_pk_q[i] + d_pr_q[3*i] + d_pr_q[3*i+1] + d_pr_q[3*i+2]);
      end
      for (int j = 0; j < 3; j++) begin
        if (d_zero_q) begin
          r_d[3*i+j] = (i == j) ? ONE_Q30[31:0] : 32'sd0;
        end else begin
          r_d[3*i+j] = d_r_q[3*i+j];
        end
      end
    end
    out_d.rot_00  = r_d[0];
    out_d.rot_01  = r_d[1];
    out_d.rot_02  = r_d[2];
    out_d.rot_10  = r_d[3];
    out_d.rot_11  = r_d[4];
    out_d.rot_12  = r_d[5];
    out_d.rot_20  = r_d[6];
    out_d.rot_21  = r_d[7];
    out_d.rot_22  = r_d[8];
    out_d.trans_x = t_d[0];
    out_d.trans_y = t_d[1];
    out_d.trans_z = t_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= cv_q[CORDIC_STEPS];
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
    end
  end

  assign out_valid_o = e_valid_q;
  assign out_data_o  = out_q;

  // The input is held off only while a finished word waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("input stalled with no word waiting at the output");

  // A stall freezes the valid bits of the inner stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(b_valid_q) && $stable(c_valid_q) && $stable(d_valid_q))
    else $error("inner stage valid changed during a stall");

  // A word in stage A reaches stage B on the next advancing edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni) adv && a_valid_q |=> b_valid_q)
    else $error("word lost between stage A and stage B");

endmodule

`default_nettype wire

### verif/tb_twist_exponential_checker.sv
// Checker for the twist exponential block: predicts each result word from the
// accepted input words and compares it field by field. Uses twexp_pkg types only.
`timescale 1ns / 1ps
`default_nettype none

module tb_twist_exponential_checker import twexp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_stall_i,
  input  wire tw_in_t  in_data_i,
  input  wire logic    out_valid_i,
  input  wire logic    out_stall_i,
  input  wire tw_out_t out_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int STEPS = 32;
  localparam longint UNIT = 64'sd1073741824;

  tw_out_t pose_queue[$];
  longint  arctan_tab[STEPS];
  longint  quarter_pi;
  longint  inv_gain;
  int      fails = 0;
  int      backlog = 0;

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // Rounded arithmetic shift, ties towards plus infinity.
  function automatic longint round_shift(input longint x, input int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return clamp32(round_shift(a * b, 30));
  endfunction

  function automatic longint unsigned series_atan(input longint unsigned m);
    longint unsigned p;
    longint unsigned acc;
    longint unsigned k;
    p = (64'd1 << 62) / m;
    acc = 0;
    k = 0;
    while (p != 0) begin
      if (k[0]) begin
        acc = acc - p / (2 * k + 1);
      end else begin
        acc = acc + p / (2 * k + 1);
      end
      p = p / m / m;
      k++;
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  initial begin
    longint unsigned p;
    longint unsigned root;
    p = 64'd1 << 60;
    for (int i = 0; i < STEPS; i++) begin
      if (2 * i < 62) p = p + (p >> (2 * i));
    end
    root = int_sqrt(p);
    inv_gain = longint'((((64'd1 << 62) / root) << 8) + ((((64'd1 << 62) % root) << 8) / root));
    quarter_pi = longint'((4 * series_atan(5) - series_atan(239) + (64'd1 << 21)) >> 22);
    arctan_tab[0] = quarter_pi;
    for (int i = 1; i < STEPS; i++) begin
      arctan_tab[i] = longint'((series_atan(64'd1 << i) + (64'd1 << 21)) >> 22);
    end
  end

  function automatic void sine_cosine(input longint ang, output longint c, output longint s);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit flip;
    a = ang * 2048;
    flip = 0;
    if (a > 2 * quarter_pi) begin
      a = a - 4 * quarter_pi;
      flip = 1;
    end else if (a < -2 * quarter_pi) begin
      a = a + 4 * quarter_pi;
      flip = 1;
    end
    x = inv_gain;
    y = 0;
    z = a;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp32(round_shift(x, 10));
    s = clamp32(round_shift(y, 10));
  endfunction

  function automatic tw_out_t predict_pose(input tw_in_t tw);
    longint v[3];
    longint w[3];
    longint rm[3][3];
    longint t[3];
    longint u[3];
    longint ang;
    longint c;
    longint s;
    longint cc;
    longint d;
    longint k;
    longint acc;
    tw_out_t res;
    v[0] = tw.lin_x;
    v[1] = tw.lin_y;
    v[2] = tw.lin_z;
    w[0] = tw.axis_x;
    w[1] = tw.axis_y;
    w[2] = tw.axis_z;
    ang = tw.angle;
    if (w[0] == 0 && w[1] == 0 && w[2] == 0) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) rm[i][j] = (i == j) ? UNIT : 0;
        t[i] = clamp32(round_shift(ang * v[i], 29));
      end
    end else begin
      sine_cosine(ang, c, s);
      cc = UNIT - c;
      rm[0][0] = clamp32(UNIT - qmul(clamp32(qmul(w[1], w[1]) + qmul(w[2], w[2])), cc));
      rm[1][1] = clamp32(UNIT - qmul(clamp32(qmul(w[0], w[0]) + qmul(w[2], w[2])), cc));
      rm[2][2] = clamp32(UNIT - qmul(clamp32(qmul(w[0], w[0]) + qmul(w[1], w[1])), cc));
      rm[0][1] = clamp32(qmul(qmul(w[0], w[1]), cc) - qmul(w[2], s));
      rm[1][0] = clamp32(qmul(qmul(w[0], w[1]), cc) + qmul(w[2], s));
      rm[0][2] = clamp32(qmul(qmul(w[0], w[2]), cc) + qmul(w[1], s));
      rm[2][0] = clamp32(qmul(qmul(w[0], w[2]), cc) - qmul(w[1], s));
      rm[1][2] = clamp32(qmul(qmul(w[1], w[2]), cc) - qmul(w[0], s));
      rm[2][1] = clamp32(qmul(qmul(w[1], w[2]), cc) + qmul(w[0], s));
      u[0] = clamp32(round_shift(w[1] * v[2], 30) - round_shift(w[2] * v[1], 30));
      u[1] = clamp32(round_shift(w[2] * v[0], 30) - round_shift(w[0] * v[2], 30));
      u[2] = clamp32(round_shift(w[0] * v[1], 30) - round_shift(w[1] * v[0], 30));
      d = clamp32(round_shift(w[0] * v[0], 30) + round_shift(w[1] * v[1], 30)
                  + round_shift(w[2] * v[2], 30));
      k = clamp32(round_shift(d * ang, 29));
      for (int i = 0; i < 3; i++) begin
        acc = round_shift(k * w[i], 30);
        for (int j = 0; j < 3; j++) begin
          acc = acc + round_shift((((i == j) ? UNIT : 0) - rm[i][j]) * u[j], 30);
        end
        t[i] = clamp32(acc);
      end
    end
    res.rot_00 = rm[0][0][31:0];
    res.rot_01 = rm[0][1][31:0];
    res.rot_02 = rm[0][2][31:0];
    res.rot_10 = rm[1][0][31:0];
    res.rot_11 = rm[1][1][31:0];
    res.rot_12 = rm[1][2][31:0];
    res.rot_20 = rm[2][0][31:0];
    res.rot_21 = rm[2][1][31:0];
    res.rot_22 = rm[2][2][31:0];
    res.trans_x = t[0][31:0];
    res.trans_y = t[1][31:0];
    res.trans_z = t[2][31:0];
    return res;
  endfunction

  assign fail_count_o = fails;
  assign pending_o    = backlog;

  always @(posedge clk_i) begin
    tw_out_t want;
    logic [31:0] got_f;
    logic [31:0] want_f;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      pose_queue.push_back(predict_pose(in_data_i));
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (pose_queue.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result word %h", out_data_i);
      end else begin
        want = pose_queue.pop_front();
        // Fields are walked from the top of the packed word, rot_00 first.
        for (int f = 0; f < 12; f++) begin
          got_f = out_data_i[383 - 32 * f -: 32];
          want_f = want[383 - 32 * f -: 32];
          if (got_f !== want_f) begin
            fails++;
            if (fails <= 10) begin
              $display("field %0d of result word: expected %h, got %h", f, want_f, got_f);
            end
          end
        end
      end
    end
    backlog = pose_queue.size();
  end

endmodule

`default_nettype wire

### verif/tb_twist_exponential_top.sv
// Testbench top for twist_exponential_top: drives twist words with random gaps
// and output stalls, and gives the verdict. Uses twexp_pkg and the checker module.
`timescale 1ns / 1ps
`default_nettype none

module tb_twist_exponential_top import twexp_pkg::*;;

  localparam int LATENCY = 38;
  localparam int RANDOM_WORDS = 1700;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  tw_in_t  in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  tw_out_t out_data_o;
  int      fail_count;
  int      pending;
  bit      calm = 1'b0;
  bit      hold_off = 1'b0;
  bit      held = 1'b0;

  always #5 clk_i = ~clk_i;

  twist_exponential_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  tb_twist_exponential_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .in_data_i(in_data_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [31:0] pick_value(input int kind);
    case (kind)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // A unit axis along one coordinate, possibly negated, a random unit-ish mix, extreme values or a zero axis.
  function automatic tw_in_t random_twist();
    tw_in_t tw;
    int shape;
    shape = $urandom_range(0, 9);
    tw.lin_x = ($urandom_range(0, 3) == 0) ? pick_value($urandom_range(0, 6))
                                           : $signed($urandom) >>> $urandom_range(0, 12);
    tw.lin_y = ($urandom_range(0, 3) == 0) ? pick_value($urandom_range(0, 6))
                                           : $signed($urandom) >>> $urandom_range(0, 12);
    tw.lin_z = ($urandom_range(0, 3) == 0) ? pick_value($urandom_range(0, 6))
                                           : $signed($urandom) >>> $urandom_range(0, 12);
    tw.angle = ($urandom_range(0, 4) == 0) ? pick_value($urandom_range(0, 6)) : $urandom;
    tw.axis_x = 0;
    tw.axis_y = 0;
    tw.axis_z = 0;
    if (shape < 5) begin
      case ($urandom_range(0, 2))
        0: tw.axis_x = $urandom_range(0, 1) ? 32'sh40000000 : -32'sh40000000;
        1: tw.axis_y = $urandom_range(0, 1) ? 32'sh40000000 : -32'sh40000000;
        default: tw.axis_z = $urandom_range(0, 1) ? 32'sh40000000 : -32'sh40000000;
      endcase
    end else if (shape < 8) begin
      tw.axis_x = $signed($urandom) >>> 2;
      tw.axis_y = $signed($urandom) >>> 2;
      tw.axis_z = $signed($urandom) >>> 2;
    end else if (shape == 8) begin
      tw.axis_x = pick_value($urandom_range(0, 6));
      tw.axis_y = pick_value($urandom_range(0, 6));
      tw.axis_z = pick_value($urandom_range(0, 6));
    end
    return tw;
  endfunction

  task automatic send_word(input tw_in_t tw);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= tw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Receiver stalls: random short bursts, and one long hold-off.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off && !held) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 1'b0;
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_twist_exponential_top: errors");
    $finish;
  end

  initial begin
    tw_in_t tw;
    int a_vals[8];
    a_vals = '{32'h7fffffff, 32'h80000000, 0, 32'h3243f6a9, 32'hcdbc0957,
               32'h1921fb54, 32'h1921fb55, 32'h6487ed51};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: zero axis, unit axes, angles around the fold points, extremes.
    for (int i = 0; i < 8; i++) begin
      tw = '0;
      tw.lin_x = 32'sh00010000;
      tw.lin_y = 32'sh7fffffff;
      tw.lin_z = 32'sh80000000;
      tw.angle = a_vals[i];
      case (i % 3)
        0: tw.axis_z = 32'sh40000000;
        1: tw.axis_x = -32'sh40000000;
        default: tw.axis_y = 32'sh40000000;
      endcase
      send_word(tw);
      tw.axis_x = 0;
      tw.axis_y = 0;
      tw.axis_z = 0;
      send_word(tw);
    end
    tw = '1;
    send_word(tw);
    tw = {7{32'h7fffffff}};
    send_word(tw);
    tw = {7{32'h80000000}};
    send_word(tw);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) hold_off = 1'b1;
      if (n == RANDOM_WORDS - 200) calm = 1'b1;
      send_word(random_twist());
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_twist_exponential_top: clean");
    end else begin
      $display("tb_twist_exponential_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
